// File: rtl/core/twsel_pkg.sv
`timescale 1ns / 1ps

package twsel_pkg;

	localparam int TAP_W = 8;
	localparam int RUN_W = 9;
	localparam int CFG_W = 9;

	// configuration register indexes
	localparam logic REG_TAP_COUNT = 1'b0;
	localparam logic REG_MIN_RUN   = 1'b1;

	// one sweep summary on its way through the fold
	typedef struct packed {
		logic [RUN_W-1:0] rem;
		logic [TAP_W-1:0] taps;
		logic             ok;
		logic [RUN_W-1:0] len;
	} twsel_win_t;

	// one restoring step of rem mod taps, at bit position k
	function automatic logic [RUN_W-1:0] mod_step(input logic [RUN_W-1:0] r,
			input logic [TAP_W-1:0] d, input int k);
		logic [RUN_W-1:0] hi;
		logic [RUN_W-1:0] dw;
		hi = r >> k;
		dw = {1'b0, d};
		if (hi >= dw) begin
			mod_step = r - RUN_W'(dw << k);
		end else begin
			mod_step = r;
		end
	endfunction

endpackage

// File: rtl/core/twsel_tracker.sv
`timescale 1ns / 1ps

module twsel_tracker #(
	parameter int MAX_TAPS = 255
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic                              tap_failed,
	input  logic [twsel_pkg::TAP_W-1:0]       tap_count,
	input  logic [twsel_pkg::RUN_W-1:0]       min_run,
	input  logic                              next_ready,
	output logic                              ready,
	output logic                              win_valid_s1,
	output twsel_pkg::twsel_win_t             win_s1
);
	import twsel_pkg::*;

	logic [RUN_W-1:0] sample_index_q;
	logic [RUN_W-1:0] current_run_q;
	logic [RUN_W-1:0] best_run_q;
	logic [RUN_W-1:0] best_start_q;
	logic [RUN_W-1:0] best_end_q;

	logic [TAP_W-1:0] taps;
	logic [RUN_W:0]   sweep_len;
	logic [RUN_W:0]   next_pos;
	logic             last;

	logic [RUN_W-1:0] cur_n;
	logic [RUN_W-1:0] run_a, start_a, end_a;
	logic [RUN_W-1:0] run_b, start_b, end_b;
	logic [RUN_W:0]   mid_sum;
	logic             ok;

	always_comb begin
		taps = tap_count;
		if (tap_count == '0) begin
			taps = TAP_W'(1);
		end else if (tap_count > TAP_W'(MAX_TAPS)) begin
			taps = TAP_W'(MAX_TAPS);
		end
	end

	assign sweep_len = {1'b0, taps, 1'b0};
	assign next_pos  = {1'b0, sample_index_q} + (RUN_W+1)'(1);
	assign last      = next_pos >= sweep_len;

	// a failing tap closes the run that ended just before it
	always_comb begin
		run_a   = best_run_q;
		start_a = best_start_q;
		end_a   = best_end_q;
		if (tap_failed) begin
			cur_n = '0;
			if (current_run_q > best_run_q) begin
				run_a   = current_run_q;
				start_a = sample_index_q - current_run_q;
				end_a   = sample_index_q - RUN_W'(1);
			end
		end else begin
			cur_n = current_run_q + RUN_W'(1);
		end
	end

	// on the final sample a run still open counts
	always_comb begin
		run_b   = run_a;
		start_b = start_a;
		end_b   = end_a;
		if (cur_n > run_a) begin
			run_b   = cur_n;
			start_b = next_pos[RUN_W-1:0] - cur_n;
			end_b   = sample_index_q;
		end
	end

	assign ok      = run_b >= min_run;
	assign mid_sum = {1'b0, start_b} + {1'b0, end_b};
	assign ready   = !win_valid_s1 || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			current_run_q  <= '0;
			best_run_q     <= '0;
			best_start_q   <= '0;
			best_end_q     <= '0;
			win_valid_s1   <= 1'b0;
		end else begin
			if (next_ready) begin
				win_valid_s1 <= 1'b0;
			end
			if (take) begin
				if (last) begin
					sample_index_q <= '0;
					current_run_q  <= '0;
					best_run_q     <= '0;
					best_start_q   <= '0;
					best_end_q     <= '0;
					win_valid_s1   <= 1'b1;
				end else begin
					sample_index_q <= next_pos[RUN_W-1:0];
					current_run_q  <= cur_n;
					best_run_q     <= run_a;
					best_start_q   <= start_a;
					best_end_q     <= end_a;
				end
			end
		end
	end

	// summary payload, loaded with the final sample of a sweep
	always_ff @(posedge clk) begin
		if (take && last) begin
			win_s1.rem  <= ok ? mid_sum[RUN_W:1] : '0;
			win_s1.taps <= taps;
			win_s1.ok   <= ok;
			win_s1.len  <= run_b;
		end
	end

endmodule

// File: rtl/core/twsel_fold.sv
`timescale 1ns / 1ps

// Reduces the window midpoint modulo the tap count: nine restoring
// steps, three per stage. The last stage is the output register.
module twsel_fold (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              win_valid_s1,
	input  twsel_pkg::twsel_win_t             win_s1,
	output logic                              ready,
	output logic                              res_valid,
	input  logic                              res_stall,
	output twsel_pkg::twsel_win_t             res
);
	import twsel_pkg::*;

	twsel_win_t win_s2, win_s3, win_s4;
	logic       valid_s2, valid_s3, valid_s4;
	logic       ready_s2, ready_s3, ready_s4;
	twsel_win_t step_a, step_b, step_c;

	assign ready_s4 = !valid_s4 || !res_stall;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready    = ready_s2;

	always_comb begin
		step_a = win_s1;
		for (int k = 8; k >= 6; k--) begin
			step_a.rem = mod_step(step_a.rem, step_a.taps, k);
		end
		step_b = win_s2;
		for (int k = 5; k >= 3; k--) begin
			step_b.rem = mod_step(step_b.rem, step_b.taps, k);
		end
		step_c = win_s3;
		for (int k = 2; k >= 0; k--) begin
			step_c.rem = mod_step(step_c.rem, step_c.taps, k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= win_valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && win_valid_s1) begin
			win_s2 <= step_a;
		end
		if (ready_s3 && valid_s2) begin
			win_s3 <= step_b;
		end
		if (ready_s4 && valid_s3) begin
			win_s4 <= step_c;
		end
	end

	assign res_valid = valid_s4;
	assign res       = win_s4;

endmodule

// File: rtl/core/tuning_window_selector.sv
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_stall  | tap_failed
// output    | out_valid / out_stall| selected_tap, window_ok, window_length
// config    | cfg_we               | cfg_index, cfg_data
//
// One tap result is taken per cycle while in_stall is low; a sweep of
// 2*tap_count samples yields one result through the summary register and
// a three-stage modulo pipeline. Reset loads tap_count 8, min_run 3 and
// clears the sweep. in_stall rises only when the summary register is full
// and the pipeline behind it cannot move, i.e. out_stall with all stages full.
module tuning_window_selector #(
	parameter int MAX_TAPS = 255
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [twsel_pkg::CFG_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              tap_failed,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [twsel_pkg::TAP_W-1:0]       selected_tap,
	output logic                              window_ok,
	output logic [twsel_pkg::RUN_W-1:0]       window_length
);
	import twsel_pkg::*;

	logic [TAP_W-1:0] tap_count_q;
	logic [RUN_W-1:0] min_run_q;
	logic             trk_ready;
	logic             fold_ready;
	logic             win_valid_s1;
	twsel_win_t       win_s1;
	twsel_win_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_W'(8);
			min_run_q   <= RUN_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAP_COUNT: tap_count_q <= cfg_data[TAP_W-1:0];
				REG_MIN_RUN:   min_run_q   <= cfg_data[RUN_W-1:0];
				default:       ;
			endcase
		end
	end

	assign in_stall = !trk_ready;

	twsel_tracker #(
		.MAX_TAPS(MAX_TAPS)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_valid && trk_ready),
		.tap_failed  (tap_failed),
		.tap_count   (tap_count_q),
		.min_run     (min_run_q),
		.next_ready  (fold_ready),
		.ready       (trk_ready),
		.win_valid_s1(win_valid_s1),
		.win_s1      (win_s1)
	);

	twsel_fold u_fold (
		.clk         (clk),
		.arst_n      (arst_n),
		.win_valid_s1(win_valid_s1),
		.win_s1      (win_s1),
		.ready       (fold_ready),
		.res_valid   (out_valid),
		.res_stall   (out_stall),
		.res         (res)
	);

	assign selected_tap  = res.rem[TAP_W-1:0];
	assign window_ok     = res.ok;
	assign window_length = res.len;

endmodule
